FILE: src/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, constants and functions of the SD SPI transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sdspi_pkg;
    localparam int BlockBytes = 512;
    localparam int CountW = $clog2(BlockBytes + 3) + 1;

    localparam logic [7:0] CmdBase   = 8'h40;
    localparam logic [7:0] IdleByte  = 8'hFF;
    localparam logic [7:0] StartTok  = 8'hFE;
    localparam logic [5:0] AppIndex  = 6'd55;

    localparam logic [2:0] StOk        = 3'd0;
    localparam logic [2:0] StR1Err     = 3'd1;
    localparam logic [2:0] StRespTmo   = 3'd2;
    localparam logic [2:0] StTokTmo    = 3'd3;
    localparam logic [2:0] StErrTok    = 3'd4;
    localparam logic [2:0] StWrReject  = 3'd5;
    localparam logic [2:0] StBadLen    = 3'd6;

    localparam logic [1:0] KindResp  = 2'd0;
    localparam logic [1:0] KindRead  = 2'd1;
    localparam logic [1:0] KindWrite = 2'd2;

    localparam logic       CmdIssue  = 1'b0;

    localparam logic [0:0] RegMaxAttempts = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD, PH_R1, PH_GAP, PH_TOKEN,
        PH_RDATA, PH_RCRC, PH_WDATA, PH_WRESP, PH_BUSY
    } t_phase;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       chip_select;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       write_taken;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] r1_value;
        logic       crc_error;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] fixed_crc(input logic [5:0] idx);
        logic [7:0] r;
        case (idx)
            6'd0:    r = 8'h95;
            6'd8:    r = 8'h87;
            6'd1:    r = 8'hF9;
            6'd55:   r = 8'h65;
            6'd41:   r = 8'h77;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: src/sd_spi_transaction_engine_unit.sv
// ----------------------------------------------------------------------------
// sd_spi_transaction_engine_unit
// SD card SPI-mode host engine; each transaction is one SPI byte slot.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata {write_byte,miso_byte,data_length,transfer_kind,
//                argument,app_command,command_index}, tuser cmd
// m_axis    out  tdata {crc_error,r1_value,status,done_res,write_taken,
//                rx_byte,rx_valid,chip_select,mosi_byte}
// apb       in   max_attempts at address 0
// One transaction per cycle while s_axis_tready is high; each result is registered
// in the output queue on acceptance. A two-entry output queue keeps input accepted
// while results wait; s_axis_tready drops only while both entries are full.
// Synchronous active-low reset idles the engine and sets max_attempts to 255.
`default_nettype none
module sd_spi_transaction_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // bits 5:0 command_index, 6 app_command, 38:7 argument, 40:39 transfer_kind,
    // 50:41 data_length, 58:51 miso_byte, 66:59 write_byte
    input  wire logic [71:0] s_axis_tdata,
    // bit 0 cmd
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // 7:0 mosi_byte, 8 chip_select, 9 rx_valid, 17:10 rx_byte, 18 write_taken,
    // 19 done_res, 22:20 status, 30:23 r1_value, 31 crc_error
    output      logic [31:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    logic [7:0] r_max_att;
    logic [31:0] r_q0, r_q1;
    logic [1:0]  r_cnt;
    logic step, pop;
    sdspi_pkg::t_result res;
    logic [31:0] res_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sdspi_pkg::RegMaxAttempts) ? {24'd0, r_max_att} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att <= 8'hFF;
        end else if (psel && penable && pwrite && paddr[2] == sdspi_pkg::RegMaxAttempts) begin
            r_max_att <= pwdata[7:0];
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign step = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata = r_q0;
    assign pop = m_axis_tvalid && m_axis_tready;

    sdspi_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_cmd(s_axis_tuser),
        .i_command_index(s_axis_tdata[5:0]),
        .i_app_command(s_axis_tdata[6]),
        .i_argument(s_axis_tdata[38:7]),
        .i_transfer_kind(s_axis_tdata[40:39]),
        .i_data_length(s_axis_tdata[50:41]),
        .i_miso_byte(s_axis_tdata[58:51]),
        .i_write_byte(s_axis_tdata[66:59]),
        .i_max_attempts(r_max_att),
        .o_result(res)
    );

    // mosi_byte in the low bits, crc_error on top
    assign res_word = {res.crc_error, res.r1_value, res.status, res.done_res,
                       res.write_taken, res.rx_byte, res.rx_valid, res.chip_select,
                       res.mosi_byte};

    // two-entry output queue: r_q0 is head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, step} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : res_word;
        end else if (step && r_cnt == 2'd0) begin
            r_q0 <= res_word;
        end
        if (step && ((r_cnt == 2'd1 && !pop) || (r_cnt == 2'd2))) begin
            r_q1 <= res_word;
        end
    end
endmodule
`default_nettype wire

FILE: src/sdspi_core.sv
// ----------------------------------------------------------------------------
// sdspi_core
// Transaction sequencer: one SPI byte slot per transaction, result computed
// combinationally from the registered state and the current slot inputs.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_cmd,
    input  wire logic [5:0]            i_command_index,
    input  wire logic                  i_app_command,
    input  wire logic [31:0]           i_argument,
    input  wire logic [1:0]            i_transfer_kind,
    input  wire logic [9:0]            i_data_length,
    input  wire logic [7:0]            i_miso_byte,
    input  wire logic [7:0]            i_write_byte,
    input  wire logic [7:0]            i_max_attempts,
    output sdspi_pkg::t_result         o_result
);
    localparam int CW = sdspi_pkg::CountW;

    sdspi_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]  r_attempt, n_attempt;
    logic [5:0]  r_index, n_index;
    logic [31:0] r_arg, n_arg;
    logic        r_app, n_app;
    logic [1:0]  r_kind, n_kind;
    logic [9:0]  r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc_rx, n_crc_rx;
    logic [7:0]  r_r1, n_r1;

    sdspi_pkg::t_result res;
    logic [5:0]  f_idx;
    logic [31:0] f_arg;
    logic [7:0]  f_byte;
    logic [1:0]  k_in;
    logic [7:0]  att_inc;
    logic [15:0] crc_new;

    // frame byte for the current count
    always_comb begin
        f_idx = r_app ? sdspi_pkg::AppIndex : r_index;
        f_arg = r_app ? 32'd0 : r_arg;
        case (r_count)
            CW'(1):  f_byte = f_arg[31:24];
            CW'(2):  f_byte = f_arg[23:16];
            CW'(3):  f_byte = f_arg[15:8];
            CW'(4):  f_byte = f_arg[7:0];
            default: f_byte = sdspi_pkg::fixed_crc(f_idx);
        endcase
    end

    always_comb begin
        n_phase = r_phase; n_count = r_count; n_attempt = r_attempt;
        n_index = r_index; n_arg = r_arg; n_app = r_app; n_kind = r_kind;
        n_len = r_len; n_crc = r_crc; n_crc_rx = r_crc_rx; n_r1 = r_r1;
        res = '0;
        res.mosi_byte = sdspi_pkg::IdleByte;
        res.chip_select = 1'b1;
        k_in = (i_transfer_kind == 2'd3) ? sdspi_pkg::KindResp : i_transfer_kind;
        att_inc = r_attempt + 8'd1;
        crc_new = sdspi_pkg::crc16_byte(r_crc, i_miso_byte);
        if (i_cmd == sdspi_pkg::CmdIssue) begin
            n_index = i_command_index; n_app = i_app_command; n_arg = i_argument;
            n_kind = k_in; n_len = i_data_length; n_r1 = sdspi_pkg::IdleByte;
            n_attempt = '0; n_crc = '0; n_crc_rx = '0;
            if (k_in != sdspi_pkg::KindResp && i_data_length > 10'(sdspi_pkg::BlockBytes)) begin
                n_phase = sdspi_pkg::PH_IDLE;
                res.chip_select = 1'b0; res.done_res = 1'b1;
                res.status = sdspi_pkg::StBadLen;
            end else begin
                n_phase = sdspi_pkg::PH_CMD;
                res.mosi_byte = sdspi_pkg::CmdBase |
                    {2'b00, i_app_command ? sdspi_pkg::AppIndex : i_command_index};
                n_count = CW'(1);
            end
        end else begin
            case (r_phase)
                sdspi_pkg::PH_CMD: begin
                    if (r_count < CW'(6)) begin
                        res.mosi_byte = f_byte;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_phase = sdspi_pkg::PH_R1; n_attempt = '0;
                    end
                end
                sdspi_pkg::PH_R1: begin
                    n_r1 = i_miso_byte; n_attempt = att_inc;
                    if (i_miso_byte[7] && att_inc < i_max_attempts) begin
                    end else if (i_miso_byte != 8'd0) begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = i_miso_byte[7] ? sdspi_pkg::StRespTmo
                                                    : sdspi_pkg::StR1Err;
                    end else if (r_app) begin
                        n_app = 1'b0; n_phase = sdspi_pkg::PH_GAP;
                        res.chip_select = 1'b0;
                    end else if (r_kind == sdspi_pkg::KindWrite) begin
                        n_phase = sdspi_pkg::PH_WDATA; n_count = '0;
                        res.mosi_byte = sdspi_pkg::StartTok;
                    end else if (r_kind == sdspi_pkg::KindRead && r_len != 10'd0) begin
                        n_phase = sdspi_pkg::PH_TOKEN; n_attempt = '0;
                    end else begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = sdspi_pkg::StOk;
                    end
                end
                sdspi_pkg::PH_GAP: begin
                    n_phase = sdspi_pkg::PH_CMD;
                    res.mosi_byte = sdspi_pkg::CmdBase | {2'b00, f_idx};
                    n_count = CW'(1);
                end
                sdspi_pkg::PH_TOKEN: begin
                    n_attempt = att_inc;
                    if (i_miso_byte == sdspi_pkg::StartTok) begin
                        n_phase = sdspi_pkg::PH_RDATA; n_count = '0; n_crc = '0;
                    end else if (i_miso_byte[7]) begin
                        if (att_inc >= i_max_attempts) begin
                            n_phase = sdspi_pkg::PH_IDLE;
                            res.chip_select = 1'b0; res.done_res = 1'b1;
                            res.status = sdspi_pkg::StTokTmo;
                        end
                    end else begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = sdspi_pkg::StErrTok;
                    end
                end
                sdspi_pkg::PH_RDATA: begin
                    res.rx_valid = 1'b1; res.rx_byte = i_miso_byte;
                    n_crc = crc_new;
                    n_count = r_count + CW'(1);
                    if ((r_count + CW'(1)) >= CW'(r_len)) begin
                        n_phase = sdspi_pkg::PH_RCRC; n_count = '0;
                    end
                end
                sdspi_pkg::PH_RCRC: begin
                    if (r_count == '0) begin
                        n_crc_rx = {i_miso_byte, 8'h00}; n_count = CW'(1);
                    end else begin
                        n_crc_rx = r_crc_rx | {8'h00, i_miso_byte};
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = sdspi_pkg::StOk;
                        res.crc_error = ((r_crc_rx | {8'h00, i_miso_byte}) != r_crc);
                    end
                end
                sdspi_pkg::PH_WDATA: begin
                    if (r_count < CW'(sdspi_pkg::BlockBytes + 2)) begin
                        if (r_count < CW'(r_len)) begin
                            res.mosi_byte = i_write_byte; res.write_taken = 1'b1;
                        end else begin
                            res.mosi_byte = 8'h00;
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_phase = sdspi_pkg::PH_WRESP;
                    end
                end
                sdspi_pkg::PH_WRESP: begin
                    if (i_miso_byte[4:0] == 5'b00101) begin
                        n_phase = sdspi_pkg::PH_BUSY;
                    end else begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = sdspi_pkg::StWrReject;
                    end
                end
                sdspi_pkg::PH_BUSY: begin
                    if (i_miso_byte != 8'd0) begin
                        n_phase = sdspi_pkg::PH_IDLE;
                        res.chip_select = 1'b0; res.done_res = 1'b1;
                        res.status = sdspi_pkg::StOk;
                    end
                end
                default: begin
                    n_phase = sdspi_pkg::PH_IDLE;
                    res.chip_select = 1'b0;
                end
            endcase
        end
        res.r1_value = n_r1;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdspi_pkg::PH_IDLE; r_count <= '0; r_attempt <= '0;
            r_index <= '0; r_arg <= '0; r_app <= 1'b0; r_kind <= '0;
            r_len <= '0; r_crc <= '0; r_crc_rx <= '0; r_r1 <= 8'hFF;
        end else if (i_step) begin
            r_phase <= n_phase; r_count <= n_count; r_attempt <= n_attempt;
            r_index <= n_index; r_arg <= n_arg; r_app <= n_app; r_kind <= n_kind;
            r_len <= n_len; r_crc <= n_crc; r_crc_rx <= n_crc_rx; r_r1 <= n_r1;
        end
    end
endmodule
`default_nettype wire

FILE: src/sdspi_checker.sv
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks of the SD SPI transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled transaction changed");
    a_done_desel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> !m_axis_tdata[8] && m_axis_tdata[7:0] == 8'hFF)
        else $error("done without deselect");
    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[17:10] == 8'h00)
        else $error("rx byte without rx valid");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[22:20] == 3'd0 && !m_axis_tdata[31])
        else $error("status without done");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind sd_spi_transaction_engine_unit sdspi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the SD SPI transaction engine against a cycle-free model of its
// byte-slot behavior. A directed table opens the run, then random command
// flows (read, write, response only, app commands, bad lengths) with noise.
// Both stream sides idle at random; one phase holds the output off for a
// long stretch while a full-block write keeps coming, so the input stalls.
// max_attempts is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    sd_spi_transaction_engine_unit dut (.*);

    typedef struct packed {
        logic       op;
        logic [5:0] idx;
        logic       app;
        logic [31:0] arg;
        logic [1:0] kind;
        logic [9:0] len;
        logic [7:0] miso;
        logic [7:0] wbyte;
    } t_slot;

    // model state
    sdspi_pkg::t_phase m_phase;
    int unsigned m_count, m_len;
    logic [7:0]  m_attempts, m_limit, m_r1;
    logic [5:0]  m_idx;
    logic [31:0] m_arg;
    logic        m_app;
    logic [1:0]  m_kind;
    logic [15:0] m_crc, m_crc_rx;

    sdspi_pkg::t_result slot_queue[$];
    int          errors, mismatches;
    int          send_idle, recv_idle;
    int          n_items;
    bit          hold_recv;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    function automatic logic [7:0] cmd_frame(int unsigned k);
        logic [5:0] ix;
        logic [31:0] a;
        ix = m_app ? sdspi_pkg::AppIndex : m_idx;
        a  = m_app ? 32'd0 : m_arg;
        case (k)
            0: return sdspi_pkg::CmdBase | {2'b00, ix};
            1: return a[31:24];
            2: return a[23:16];
            3: return a[15:8];
            4: return a[7:0];
            default:
                case (ix)
                    6'd0:  return 8'h95;
                    6'd8:  return 8'h87;
                    6'd1:  return 8'hF9;
                    6'd55: return 8'h65;
                    6'd41: return 8'h77;
                    default: return sdspi_pkg::IdleByte;
                endcase
        endcase
    endfunction

    function automatic void end_flow(ref sdspi_pkg::t_result r, input logic [2:0] st);
        m_phase = sdspi_pkg::PH_IDLE;
        r.mosi_byte = sdspi_pkg::IdleByte;
        r.chip_select = 0;
        r.done_res = 1;
        r.status = st;
    endfunction

    function automatic sdspi_pkg::t_result predict_slot(t_slot s);
        sdspi_pkg::t_result r;
        r = '0;
        r.mosi_byte = sdspi_pkg::IdleByte;
        r.chip_select = 1;
        if (s.op == sdspi_pkg::CmdIssue) begin
            m_idx = s.idx; m_app = s.app; m_arg = s.arg;
            m_kind = (s.kind == 2'd3) ? sdspi_pkg::KindResp : s.kind;
            m_len = s.len; m_r1 = sdspi_pkg::IdleByte; m_attempts = 0;
            m_crc = 0; m_crc_rx = 0;
            if (m_kind != sdspi_pkg::KindResp && m_len > sdspi_pkg::BlockBytes) begin
                end_flow(r, sdspi_pkg::StBadLen);
            end else begin
                m_phase = sdspi_pkg::PH_CMD;
                r.mosi_byte = cmd_frame(0);
                m_count = 1;
            end
            r.r1_value = m_r1;
            return r;
        end
        case (m_phase)
            sdspi_pkg::PH_CMD: begin
                if (m_count < 6) begin
                    r.mosi_byte = cmd_frame(m_count);
                    m_count++;
                end else begin
                    m_phase = sdspi_pkg::PH_R1;
                    m_attempts = 0;
                end
            end
            sdspi_pkg::PH_R1: begin
                m_r1 = s.miso;
                m_attempts++;
                if (!(s.miso[7] && m_attempts < m_limit)) begin
                    if (s.miso != 0)
                        end_flow(r, s.miso[7] ? sdspi_pkg::StRespTmo : sdspi_pkg::StR1Err);
                    else if (m_app) begin
                        m_app = 0; m_phase = sdspi_pkg::PH_GAP; r.chip_select = 0;
                    end else if (m_kind == sdspi_pkg::KindWrite) begin
                        m_phase = sdspi_pkg::PH_WDATA; m_count = 0;
                        r.mosi_byte = sdspi_pkg::StartTok;
                    end else if (m_kind == sdspi_pkg::KindRead && m_len != 0) begin
                        m_phase = sdspi_pkg::PH_TOKEN; m_attempts = 0;
                    end else end_flow(r, sdspi_pkg::StOk);
                end
            end
            sdspi_pkg::PH_GAP: begin
                m_phase = sdspi_pkg::PH_CMD;
                r.mosi_byte = cmd_frame(0);
                m_count = 1;
            end
            sdspi_pkg::PH_TOKEN: begin
                m_attempts++;
                if (s.miso == sdspi_pkg::StartTok) begin
                    m_phase = sdspi_pkg::PH_RDATA; m_count = 0; m_crc = 0;
                end else if (s.miso[7]) begin
                    if (m_attempts >= m_limit) end_flow(r, sdspi_pkg::StTokTmo);
                end else end_flow(r, sdspi_pkg::StErrTok);
            end
            sdspi_pkg::PH_RDATA: begin
                r.rx_valid = 1;
                r.rx_byte = s.miso;
                m_crc = crc_step(m_crc, s.miso);
                m_count++;
                if (m_count >= m_len) begin
                    m_phase = sdspi_pkg::PH_RCRC; m_count = 0;
                end
            end
            sdspi_pkg::PH_RCRC: begin
                if (m_count == 0) begin
                    m_crc_rx = {s.miso, 8'h00}; m_count = 1;
                end else begin
                    m_crc_rx[7:0] = s.miso;
                    end_flow(r, sdspi_pkg::StOk);
                    r.crc_error = (m_crc_rx != m_crc);
                end
            end
            sdspi_pkg::PH_WDATA: begin
                if (m_count < sdspi_pkg::BlockBytes + 2) begin
                    if (m_count < m_len) begin
                        r.mosi_byte = s.wbyte; r.write_taken = 1;
                    end else r.mosi_byte = 0;
                    m_count++;
                end else m_phase = sdspi_pkg::PH_WRESP;
            end
            sdspi_pkg::PH_WRESP: begin
                if (s.miso[4:0] == 5'b00101) m_phase = sdspi_pkg::PH_BUSY;
                else end_flow(r, sdspi_pkg::StWrReject);
            end
            sdspi_pkg::PH_BUSY: if (s.miso != 0) end_flow(r, sdspi_pkg::StOk);
            default: begin
                m_phase = sdspi_pkg::PH_IDLE; r.chip_select = 0;
            end
        endcase
        r.r1_value = m_r1;
        return r;
    endfunction

    // Expected result typed in for directed rows; '1 in has_fixed marks it
    task automatic send_slot(t_slot s, bit has_fixed = 0, sdspi_pkg::t_result fixed = '0);
        sdspi_pkg::t_result r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        r = predict_slot(s);
        if (has_fixed && r != fixed) begin
            errors++;
            $display("directed row disagrees: table %h model %h", fixed, r);
        end
        slot_queue.push_back(r);
        n_items++;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= s.op;
        s_axis_tdata  <= {5'd0, s.wbyte, s.miso, s.len, s.kind, s.arg, s.app, s.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic slot(logic [7:0] miso, logic [7:0] wbyte = 0);
        t_slot s;
        s = '0;
        s.op = 1; s.miso = miso; s.wbyte = wbyte;
        send_slot(s);
    endtask

    task automatic issue(logic [5:0] idx, logic app, logic [31:0] arg, logic [1:0] kind,
                         logic [9:0] len);
        t_slot s;
        s = '{sdspi_pkg::CmdIssue, idx, app, arg, kind, len, 8'($urandom), 8'($urandom)};
        send_slot(s);
    endtask

    task automatic apb_write(logic [7:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 3'(4 * sdspi_pkg::RegMaxAttempts);
        pwdata <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        m_limit = v;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        while (slot_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random miso byte biased toward the answer that advances the flow
    function automatic logic [7:0] r1_byte;
        int p;
        p = $urandom_range(99);
        if (p < 70) return 8'h00;
        if (p < 85) return 8'h80 | 8'($urandom);
        return 8'($urandom_range(1, 127));
    endfunction

    // full_write runs one complete block write; other writes are cut short
    task automatic random_flow(bit full_write = 0);
        int p, n, len, limit;
        logic [1:0] kind;
        logic [5:0] idx;
        p = $urandom_range(99);
        kind = full_write ? sdspi_pkg::KindWrite :
               (p < 35) ? sdspi_pkg::KindRead :
               (p < 70) ? sdspi_pkg::KindWrite : 2'($urandom);
        idx = ($urandom_range(3) == 0) ? 6'($urandom) :
              ($urandom_range(1) ? 6'd17 : 6'd24);
        len = full_write ? $urandom_range(500, 512)
              : ($urandom_range(19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        issue(idx, $urandom_range(3) == 0, $urandom, kind, 10'(len));
        if (kind != sdspi_pkg::KindResp && kind != 2'd3 && len > sdspi_pkg::BlockBytes) return;
        limit = (kind == sdspi_pkg::KindWrite && !full_write) ? $urandom_range(4, 40) : 700;
        n = 0;
        // walk slots until the model goes idle, the slot limit is reached or noise cuts in
        while (m_phase != sdspi_pkg::PH_IDLE && n < limit) begin
            n++;
            if (!full_write && $urandom_range(499) == 0) return;
            case (m_phase)
                sdspi_pkg::PH_R1:    slot(full_write ? 8'h00 : r1_byte());
                sdspi_pkg::PH_TOKEN: slot($urandom_range(2) != 0 ? sdspi_pkg::StartTok :
                               ($urandom_range(4) != 0 ? 8'hFF : 8'($urandom)));
                sdspi_pkg::PH_WRESP: slot($urandom_range(3) != 0 ? {3'($urandom), 5'b00101}
                               : 8'($urandom));
                sdspi_pkg::PH_BUSY:  slot($urandom_range(2) != 0 ? 8'h00 : 8'($urandom));
                sdspi_pkg::PH_RCRC:  slot($urandom_range(1) ?
                               (m_count == 0 ? m_crc[15:8] : m_crc[7:0]) : 8'($urandom));
                default:  slot(8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        sdspi_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = sdspi_pkg::t_result'({m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9],
                             m_axis_tdata[17:10], m_axis_tdata[18], m_axis_tdata[19],
                             m_axis_tdata[22:20], m_axis_tdata[30:23], m_axis_tdata[31]});
            if (slot_queue.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = slot_queue.pop_front();
                if (got != want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: mosi %h/%h cs %b/%b rxv %b/%b rx %h/%h wt %b/%b done %b/%b st %0d/%0d r1 %h/%h crc %b/%b",
                            want.mosi_byte, got.mosi_byte, want.chip_select, got.chip_select,
                            want.rx_valid, got.rx_valid, want.rx_byte, got.rx_byte,
                            want.write_taken, got.write_taken, want.done_res, got.done_res,
                            want.status, got.status, want.r1_value, got.r1_value,
                            want.crc_error, got.crc_error);
                end
            end
        end
    end

    // receiver ready, updated at the falling edge
    always @(negedge i_clk) begin
        if (hold_recv) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        t_slot   rows[$];
        sdspi_pkg::t_result fixed[$];
        bit      has_fix[$];
        sdspi_pkg::t_result r;
        int      phase_end;
        s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
        m_axis_tready = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hold_recv = 0; send_idle = 0; recv_idle = 0;
        errors = 0; mismatches = 0; n_items = 0;
        m_phase = sdspi_pkg::PH_IDLE; m_count = 0; m_attempts = 0; m_idx = 0; m_arg = 0;
        m_app = 0; m_kind = 0; m_len = 0; m_crc = 0; m_crc_rx = 0;
        m_r1 = sdspi_pkg::IdleByte; m_limit = 255;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed table: slot while idle, bad length, extremes of fields
        r = '0; r.mosi_byte = sdspi_pkg::IdleByte; r.r1_value = sdspi_pkg::IdleByte;
        rows.push_back('{1'b1, 6'd0, 1'b0, 32'd0, 2'd0, 10'd0, 8'hFF, 8'hFF});
        fixed.push_back(r); has_fix.push_back(1);
        r.done_res = 1; r.status = sdspi_pkg::StBadLen;
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd63, 1'b1, 32'hFFFF_FFFF,
                         sdspi_pkg::KindRead, 10'd1023, 8'h0, 8'h0});
        fixed.push_back(r); has_fix.push_back(1);
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd24, 1'b0, 32'd0,
                         sdspi_pkg::KindWrite, 10'd513, 8'h0, 8'h0});
        fixed.push_back(r); has_fix.push_back(1);
        // CMD0, then R1 error
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd0, 1'b0, 32'h0, 2'd3, 10'd0, 8'h0, 8'h0});
        rows.push_back('{1'b1, 6'd63, 1'b1, 32'hFFFF_FFFF, 2'd3, 10'd1023, 8'h0, 8'h0});
        for (int k = 0; k < 6; k++)
            rows.push_back('{1'b1, 6'd0, 1'b0, 32'h0, 2'd0, 10'd0, 8'hFF, 8'hFF});
        rows.push_back('{1'b1, 6'd0, 1'b0, 32'h0, 2'd0, 10'd0, 8'h01, 8'h0});
        // app CMD41 read of length zero, CMD8 read of length one, then response-only CMD1 and CMD55
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd41, 1'b1, 32'h4000_0000,
                         sdspi_pkg::KindRead, 10'd0, 8'h0, 8'h0});
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd8, 1'b0, 32'h1AA,
                         sdspi_pkg::KindRead, 10'd1, 8'h0, 8'h0});
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd1, 1'b0, 32'h0,
                         sdspi_pkg::KindResp, 10'd0, 8'h0, 8'h0});
        rows.push_back('{sdspi_pkg::CmdIssue, 6'd55, 1'b0, 32'h0,
                         sdspi_pkg::KindResp, 10'd0, 8'h0, 8'h0});
        while (has_fix.size() < rows.size()) begin
            has_fix.push_back(0); fixed.push_back('0);
        end
        foreach (rows[k]) send_slot(rows[k], has_fix[k], fixed[k]);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 30; recv_idle = 63; apb_write(8'd255); end
                1: begin send_idle = 63; recv_idle = 30; apb_write(8'd1); end
                2: begin send_idle = 0;  recv_idle = 0;  apb_write(8'd0); end
                3: begin send_idle = 10; recv_idle = 10; apb_write(8'd4); end
            endcase
            if (ph == 2) begin
                // long receiver hold-off while a full block write keeps coming
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge i_clk);
                        hold_recv = 0;
                    end
                    random_flow(1'b1);
                join
            end
            phase_end = n_items + 200;
            while (n_items < phase_end) begin
                random_flow();
                if (slot_queue.size() > 0 && $urandom_range(7) == 0) slot(8'($urandom));
            end
            drain();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
src/sdspi_pkg.sv
src/sdspi_core.sv
src/sd_spi_transaction_engine_unit.sv
src/sdspi_checker.sv
bench/tb.sv
